@@ hdl/hps_pkg.sv @@
// Package with shared types, format codes and per-code threshold tables.
`timescale 1ns / 1ps
package hps_pkg;

    typedef enum logic [1:0] {
        FMT_PASS   = 2'd0,
        FMT_HALF   = 2'd1,
        FMT_SINGLE = 2'd2
    } t_fmt;

    localparam logic [0:0] REG_SOURCE_FORMAT = 1'b0;
    localparam int unsigned LANE_STAGES = 9;
    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
    localparam logic [31:0] SEARCH_LO = 32'h3000_0000;

    typedef logic [31:0] t_thr_tab [256];

    function automatic logic [511:0] pow_n(input logic [511:0] b, input int n);
        logic [511:0] r;
        r = 512'd1;
        for (int i = 0; i < n; i++) begin
            r = r * b;
        end
        return r;
    endfunction

    function automatic bit thr_ok(input bit is_alpha, input int k, input logic [31:0] bits);
        logic [511:0] m;
        logic [511:0] lhs;
        logic [511:0] rhs;
        int s;
        m = {488'd0, 1'b1, bits[22:0]};
        s = 150 - int'(bits[30:23]);
        if (is_alpha) begin
            lhs = m * 512'd510;
            rhs = 512'(2 * k - 1) << s;
        end else if (k <= 10) begin
            lhs = m * 512'd32946;
            rhs = 512'((2 * k - 1) * 5) << s;
        end else begin
            lhs = pow_n(m, 5) * pow_n(512'd10761, 12);
            rhs = pow_n(512'(40 * k + 541), 12) << (5 * s);
        end
        return lhs >= rhs;
    endfunction

    function automatic t_thr_tab build_tab(input bit is_alpha);
        t_thr_tab tab;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        tab[0] = 32'd0;
        for (int k = 1; k < 256; k++) begin
            lo = SEARCH_LO;
            hi = ONE_BITS;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (thr_ok(is_alpha, k, mid)) begin
                    hi = mid;
                end else begin
                    lo = mid + 32'd1;
                end
            end
            tab[k] = lo;
        end
        return tab;
    endfunction

    localparam t_thr_tab SRGB_THR  = build_tab(1'b0);
    localparam t_thr_tab ALPHA_THR = build_tab(1'b1);

endpackage

@@ hdl/hps_if.sv @@
// Stream interfaces for pixel requests and byte results.
`timescale 1ns / 1ps
interface hps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
    logic [31:0] alpha_in;
    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface hps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

@@ hdl/hps_lane.sv @@
// One channel lane: decode, special cases and a pipelined threshold search.
`timescale 1ns / 1ps
module hps_lane #(
    parameter bit IS_ALPHA = 1'b0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [1:0]  i_fmt,
    input  logic [31:0] i_data,
    output logic [7:0]  o_code
);

    logic [31:0] n_bits;
    logic        n_forced;
    logic [7:0]  n_fbyte;
    logic [31:0] f32;

    logic [30:0] r_mag   [8];
    logic        r_forced[8];
    logic [7:0]  r_fbyte [8];
    logic [7:0]  r_code  [8];
    logic [7:0]  r_final;

    always_comb begin
        n_bits = i_data;
        if (i_fmt == hps_pkg::FMT_HALF) begin
            if (i_data[14:10] == 5'd31) begin
                n_bits = {i_data[15], 8'hFF, i_data[9:0], 13'd0};
            end else if (i_data[14:10] == 5'd0) begin
                n_bits = {i_data[15], 31'd0};
            end else begin
                n_bits = {i_data[15], 3'd0, i_data[14:10] + 5'd0, i_data[9:0], 13'd0};
                n_bits[30:23] = {3'd0, i_data[14:10]} + 8'd112;
            end
        end
        f32 = n_bits;
        n_forced = 1'b1;
        n_fbyte  = 8'd0;
        if (i_fmt != hps_pkg::FMT_HALF && i_fmt != hps_pkg::FMT_SINGLE) begin
            n_fbyte = i_data[7:0];
        end else if (f32[30:23] == 8'hFF) begin
            n_fbyte = (f32[22:0] == 23'd0 && !f32[31]) ? 8'd255 : 8'd0;
        end else if (f32[31]) begin
            n_fbyte = 8'd0;
        end else if (f32 >= hps_pkg::ONE_BITS) begin
            n_fbyte = 8'd255;
        end else begin
            n_forced = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0]    <= f32[30:0];
            r_forced[0] <= n_forced;
            r_fbyte[0]  <= n_fbyte;
            r_code[0]   <= 8'd0;
        end
    end

    for (genvar g = 1; g < 8; g++) begin : g_stage
        logic [7:0]  cand;
        logic [31:0] thr;
        assign cand = r_code[g-1] | (8'd1 << (8 - g));
        assign thr  = IS_ALPHA ? hps_pkg::ALPHA_THR[cand] : hps_pkg::SRGB_THR[cand];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[g]    <= r_mag[g-1];
                r_forced[g] <= r_forced[g-1];
                r_fbyte[g]  <= r_fbyte[g-1];
                r_code[g]   <= (r_mag[g-1] >= thr[30:0]) ? cand : r_code[g-1];
            end
        end
    end

    logic [7:0]  last_cand;
    logic [31:0] last_thr;
    assign last_cand = r_code[7] | 8'd1;
    assign last_thr  = IS_ALPHA ? hps_pkg::ALPHA_THR[last_cand]
                                : hps_pkg::SRGB_THR[last_cand];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_forced[7]) begin
                r_final <= r_fbyte[7];
            end else begin
                r_final <= (r_mag[7] >= last_thr[30:0]) ? last_cand : r_code[7];
            end
        end
    end

    assign o_code = r_final;

endmodule

@@ hdl/hdr_pixel_to_srgb8.sv @@
// Top level: configuration register, four channel lanes and the output stage.
//
// Channel   Dir  Kind    Carries
// i_pix     in   stream  red_in, green_in, blue_in, alpha_in (32 bits each)
// o_pix     out  stream  red_out, green_out, blue_out, alpha_out (8 bits each)
// APB       in   config  source_format at address 0
//
// One pixel is accepted per cycle unless the output stage is stalled.
// Each lane decodes its input and runs an eight-step threshold search, followed by the output register.
// Reset is synchronous and clears the valid pipeline and source_format.
// The whole pipeline holds while a result waits and o_pix.ready is low.
`timescale 1ns / 1ps
module hdr_pixel_to_srgb8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hps_in_if.sink      i_pix,
    hps_out_if.source   o_pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] r_fmt;
    logic [hps_pkg::LANE_STAGES-1:0] r_vld;
    logic       r_ovld;
    logic [7:0] r_red, r_green, r_blue, r_alpha;
    logic [7:0] c_red, c_green, c_blue, c_alpha;
    logic       adv;

    assign pready = 1'b1;
    assign prdata = (paddr == hps_pkg::REG_SOURCE_FORMAT) ? {30'd0, r_fmt} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= hps_pkg::FMT_PASS;
        end else if (psel && penable && pwrite && paddr == hps_pkg::REG_SOURCE_FORMAT) begin
            r_fmt <= pwdata[1:0];
        end
    end

    assign adv         = !r_ovld || o_pix.ready;
    assign i_pix.ready = adv;

    hps_lane #(.IS_ALPHA(1'b0)) u_red (
        .i_clk(i_clk), .i_en(adv), .i_fmt(r_fmt), .i_data(i_pix.red_in), .o_code(c_red));
    hps_lane #(.IS_ALPHA(1'b0)) u_green (
        .i_clk(i_clk), .i_en(adv), .i_fmt(r_fmt), .i_data(i_pix.green_in), .o_code(c_green));
    hps_lane #(.IS_ALPHA(1'b0)) u_blue (
        .i_clk(i_clk), .i_en(adv), .i_fmt(r_fmt), .i_data(i_pix.blue_in), .o_code(c_blue));
    hps_lane #(.IS_ALPHA(1'b1)) u_alpha (
        .i_clk(i_clk), .i_en(adv), .i_fmt(r_fmt), .i_data(i_pix.alpha_in), .o_code(c_alpha));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_vld  <= {r_vld[hps_pkg::LANE_STAGES-2:0], i_pix.valid};
            r_ovld <= r_vld[hps_pkg::LANE_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_red   <= c_red;
            r_green <= c_green;
            r_blue  <= c_blue;
            r_alpha <= c_alpha;
        end
    end

    assign o_pix.valid     = r_ovld;
    assign o_pix.red_out   = r_red;
    assign o_pix.green_out = r_green;
    assign o_pix.blue_out  = r_blue;
    assign o_pix.alpha_out = r_alpha;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !r_ovld && r_vld == '0)
        else $error("valid pipeline not cleared by reset");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready == (!o_pix.valid || o_pix.ready))
        else $error("input ready does not follow output stage");
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline moved during a stall");
    a_feed_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_vld[hps_pkg::LANE_STAGES-1] |=> r_ovld)
        else $error("finished item lost before output");

endmodule

@@ tb/hps_tb_if.sv @@
// Bus interface used by the testbench for the register port.
`timescale 1ns / 1ps
interface hps_apb_if;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
endinterface

@@ tb/tb_top.sv @@
// Testbench for hdr_pixel_to_srgb8: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] FMT_SPARE = 2'd3;
    localparam int LATENCY = 12;

    logic i_clk;
    logic i_rst_n;
    hps_in_if  pix_in ();
    hps_out_if pix_out ();
    hps_apb_if apb ();

    hdr_pixel_to_srgb8 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in.sink),
        .o_pix   (pix_out.source),
        .psel    (apb.psel),
        .penable (apb.penable),
        .pwrite  (apb.pwrite),
        .paddr   (apb.paddr),
        .pwdata  (apb.pwdata),
        .prdata  (apb.prdata),
        .pready  (apb.pready)
    );

    logic [3:0][7:0] expected_bytes [$];
    logic [1:0]      cur_fmt;
    logic [511:0]    code_pow12 [256];
    logic [511:0]    slope_pow12;
    int              fail_count;
    bit              stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [511:0] pow12(input logic [511:0] b);
        logic [511:0] r;
        r = 512'd1;
        for (int i = 0; i < 12; i++) r = r * b;
        return r;
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
        if (h[14:10] == 5'd0) return {h[15], 31'd0};
        return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
    endfunction

    function automatic bit clamp_code(input logic [31:0] bits, output logic [7:0] code);
        if (bits[30:23] == 8'hFF) begin
            code = (bits[22:0] == 23'd0 && !bits[31]) ? 8'd255 : 8'd0;
            return 1'b1;
        end
        if (bits[31]) begin
            code = 8'd0;
            return 1'b1;
        end
        if (bits >= 32'h3F80_0000) begin
            code = 8'd255;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] srgb_code(input logic [31:0] bits);
        logic [7:0]   code;
        logic [63:0]  mant;
        logic [511:0] lhs;
        int           e;
        int           s;
        int           lo;
        int           hi;
        int           mid;
        if (clamp_code(bits, code)) return code;
        e = int'(bits[30:23]);
        if (e < 114) return 8'd0;
        mant = {40'd0, 1'b1, bits[22:0]};
        s = 150 - e;
        code = 8'd0;
        if (e >= 119) begin
            code = 8'd10;
        end else begin
            for (int k = 1; k <= 10; k++)
                if (mant * 64'd32946 >= (64'((2 * k - 1) * 5) << s)) code = 8'(k);
        end
        if (e < 118) return code;
        lhs = 512'd1;
        for (int i = 0; i < 5; i++) lhs = lhs * 512'(mant);
        lhs = lhs * slope_pow12;
        if (lhs >= (code_pow12[11] << (5 * s))) begin
            lo = 11;
            hi = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (lhs >= (code_pow12[mid] << (5 * s))) lo = mid;
                else hi = mid - 1;
            end
            code = 8'(lo);
        end
        return code;
    endfunction

    function automatic logic [7:0] alpha_code(input logic [31:0] bits);
        logic [7:0]  code;
        logic [63:0] mant;
        int          s;
        if (clamp_code(bits, code)) return code;
        if (int'(bits[30:23]) < 117) return 8'd0;
        mant = {40'd0, 1'b1, bits[22:0]};
        s = 150 - int'(bits[30:23]);
        return 8'(((mant * 64'd510) + (64'd1 << s)) >> (s + 1));
    endfunction

    function automatic logic [3:0][7:0] predict_bytes(input logic [3:0][31:0] chan);
        logic [3:0][7:0]  res;
        logic [3:0][31:0] bits;
        for (int i = 0; i < 4; i++)
            bits[i] = (cur_fmt == hps_pkg::FMT_HALF) ? widen_half(chan[i][15:0]) : chan[i];
        if (cur_fmt == hps_pkg::FMT_HALF || cur_fmt == hps_pkg::FMT_SINGLE) begin
            for (int i = 0; i < 3; i++) res[i] = srgb_code(bits[i]);
            res[3] = alpha_code(bits[3]);
        end else begin
            for (int i = 0; i < 4; i++) res[i] = bits[i][7:0];
        end
        return res;
    endfunction

    task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b, input logic [31:0] a);
        logic [3:0][31:0] chan;
        int gap;
        if (stalls_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        chan = {a, b, g, r};
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= r;
        pix_in.green_in <= g;
        pix_in.blue_in  <= b;
        pix_in.alpha_in <= a;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        expected_bytes.push_back(predict_bytes(chan));
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_format(input logic [1:0] fmt);
        wait_drained();
        apb.psel    <= 1'b1;
        apb.penable <= 1'b0;
        apb.pwrite  <= 1'b1;
        apb.paddr   <= hps_pkg::REG_SOURCE_FORMAT;
        apb.pwdata  <= {$urandom() & 32'hFFFF_FFFC} | 32'(fmt);
        @(posedge i_clk);
        apb.penable <= 1'b1;
        @(posedge i_clk);
        apb.pwrite  <= 1'b0;
        apb.penable <= 1'b0;
        @(posedge i_clk);
        apb.penable <= 1'b1;
        @(posedge i_clk);
        if (apb.prdata[1:0] !== fmt) begin
            $display("%0t source_format readback expected %h actual %h", $time, fmt,
                     apb.prdata[1:0]);
            fail_count++;
        end
        apb.psel    <= 1'b0;
        apb.penable <= 1'b0;
        cur_fmt = fmt;
    endtask

    function automatic logic [31:0] rand_channel();
        logic [31:0] v;
        v = $urandom();
        if (cur_fmt == hps_pkg::FMT_HALF) begin
            case ($urandom_range(0, 9))
                0: ;
                1: v[15:0] = {$urandom_range(0, 1) == 1, 5'd31, 10'($urandom_range(0, 3))};
                2: v[15:0] = {$urandom_range(0, 1) == 1, 5'd0, 10'($urandom())};
                default: v[15:0] = {($urandom_range(0, 15) == 0), 5'($urandom_range(1, 15)),
                                    10'($urandom())};
            endcase
        end else if (cur_fmt == hps_pkg::FMT_SINGLE) begin
            case ($urandom_range(0, 9))
                0: ;
                1: v = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
                default: v = {($urandom_range(0, 15) == 0), 8'($urandom_range(108, 127)),
                              23'($urandom())};
            endcase
        end
        return v;
    endfunction

    task automatic random_pixels(input int count);
        for (int n = 0; n < count; n++)
            send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    endtask

    task automatic test_pass_through();
        set_format(hps_pkg::FMT_PASS);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_56AB, 32'hFFFF_FF00);
        send_pixel(32'h0000_00FF, 32'h0000_0001, 32'h8000_0080, 32'h7F00_007F);
        random_pixels(60);
    endtask

    task automatic test_spare_format();
        set_format(FMT_SPARE);
        send_pixel(32'h3F80_0000, 32'hDEAD_BEEF, 32'h0000_3C00, 32'hFFFF_FFFF);
        random_pixels(60);
    endtask

    task automatic test_single_directed();
        set_format(hps_pkg::FMT_SINGLE);
        send_pixel(32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000);
        send_pixel(32'h7FC0_0000, 32'h3F80_0000, 32'h3F7F_FFFF, 32'h3F7F_FFFF);
        send_pixel(32'h3B4D_2E1C, 32'h3B4D_2E1D, 32'h0000_0001, 32'h3F00_0000);
        send_pixel(32'h4780_0000, 32'hBF80_0000, 32'h3900_0000, 32'h3B00_0000);
        send_pixel(32'h7FFF_FFFF, 32'h3C00_0000, 32'h3A80_0000, 32'h7F80_0000);
    endtask

    task automatic test_half_directed();
        set_format(hps_pkg::FMT_HALF);
        send_pixel(32'h0000_3C00, 32'h0000_3BFF, 32'h0000_8000, 32'h0000_7C00);
        send_pixel(32'h0000_FC00, 32'h0000_7E00, 32'h0000_0001, 32'hFFFF_3800);
        send_pixel(32'h0000_03FF, 32'h0000_1A6B, 32'hABCD_0000, 32'h0000_1C00);
        send_pixel(32'h0000_4000, 32'h0000_BC00, 32'h0000_2000, 32'h0000_0400);
    endtask

    task automatic test_random_formats();
        set_format(hps_pkg::FMT_SINGLE);
        random_pixels(400);
        set_format(hps_pkg::FMT_HALF);
        random_pixels(200);
        wait_drained();
        random_pixels(200);
        set_format(hps_pkg::FMT_PASS);
        random_pixels(100);
        set_format(hps_pkg::FMT_SINGLE);
        stalls_on = 1'b0;
        random_pixels(200);
        set_format(hps_pkg::FMT_HALF);
        random_pixels(200);
        wait_drained();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_out.valid && pix_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t result with nothing expected: actual %h", $time,
                             {pix_out.alpha_out, pix_out.blue_out, pix_out.green_out,
                              pix_out.red_out});
                    fail_count++;
                end else begin
                    logic [3:0][7:0] exp_px;
                    logic [3:0][7:0] act_px;
                    exp_px = expected_bytes.pop_front();
                    act_px = {pix_out.alpha_out, pix_out.blue_out, pix_out.green_out,
                              pix_out.red_out};
                    for (int i = 0; i < 4; i++)
                        if (act_px[i] !== exp_px[i]) begin
                            $display("%0t channel %0d expected %h actual %h", $time, i,
                                     exp_px[i], act_px[i]);
                            fail_count++;
                        end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pix_out.ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    initial begin
        int waited;
        slope_pow12 = pow12(512'd10761);
        for (int k = 0; k < 256; k++) code_pow12[k] = pow12(512'(40 * k + 541));
        fail_count = 0;
        stalls_on = 1'b1;
        cur_fmt = hps_pkg::FMT_PASS;
        i_rst_n <= 1'b0;
        pix_in.valid <= 1'b0;
        pix_in.red_in <= '0;
        pix_in.green_in <= '0;
        pix_in.blue_in <= '0;
        pix_in.alpha_in <= '0;
        apb.psel <= 1'b0;
        apb.penable <= 1'b0;
        apb.pwrite <= 1'b0;
        apb.paddr <= '0;
        apb.pwdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_pixel(32'h0000_0012, 32'h0000_0034, 32'h0000_0056, 32'h0000_0078);
        test_pass_through();
        test_spare_format();
        test_single_directed();
        test_half_directed();
        test_random_formats();
        waited = 0;
        while (expected_bytes.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            $display("%0t %0d results never arrived", $time, expected_bytes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
